// File: hw/rtl/priority_guided_path_decoder_defines.svh
// Assertion macros used by the decoder's top-level RTL.
`ifndef PRIORITY_GUIDED_PATH_DECODER_DEFINES_SVH
`define PRIORITY_GUIDED_PATH_DECODER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PGPD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pgpd: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define PGPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pgpd: next-cycle check failed");

`endif

// File: hw/rtl/pgpd_pkg.sv
package pgpd_pkg;

	// Fixed field widths of the transaction payloads.
	localparam int VERTEX_W       = 5;
	localparam int WEIGHT_FIELD_W = 8;
	localparam int PRIO_FIELD_W   = 16;
	localparam int TOTAL_W        = 13;
	localparam logic [TOTAL_W-1:0] TOTAL_MAX = 13'd8191;

	// Longest path that a run may report.
	localparam int MAX_RESULTS = 32;

	// Defaults of the top-level parameters.
	localparam int NUM_VERTICES_DEF  = 32;
	localparam int WEIGHT_BITS_DEF   = 8;
	localparam int PRIORITY_BITS_DEF = 16;

	// Configuration registers.
	localparam int CFG_IDX_W = 1;
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_START_VERTEX = 1'b0,
		CFG_END_VERTEX   = 1'b1
	} cfg_reg_t;
	localparam logic [VERTEX_W-1:0] START_RESET = 5'd0;
	localparam logic [VERTEX_W-1:0] END_RESET   = 5'd31;

	// Input item modes; the fourth code is ignored.
	typedef enum logic [1:0] {
		MODE_EDGE = 2'd0,
		MODE_PRIO = 2'd1,
		MODE_RUN  = 2'd2
	} mode_t;

	typedef struct packed {
		logic [1:0]                mode;
		logic [VERTEX_W-1:0]       row_vertex;
		logic [VERTEX_W-1:0]       col_vertex;
		logic [WEIGHT_FIELD_W-1:0] edge_weight;
		logic [PRIO_FIELD_W-1:0]   priority_value;
	} in_item_t;

	typedef struct packed {
		logic [VERTEX_W-1:0]       vertex;
		logic [WEIGHT_FIELD_W-1:0] step_weight;
		logic [TOTAL_W-1:0]        total_weight;
		logic                      last;
		logic                      failed;
	} out_item_t;

	// Datapath actions selected by the control word.
	typedef enum logic [3:0] {
		ACT_NOP,
		ACT_WAIT,
		ACT_INIT,
		ACT_RECORD,
		ACT_SCAN,
		ACT_MOVE,
		ACT_EMIT_INIT,
		ACT_EMIT_PUSH,
		ACT_FAIL_PUSH
	} act_t;

	// Jump conditions selected by the control word.
	typedef enum logic [3:0] {
		COND_NEVER,
		COND_ALWAYS,
		COND_NO_RUN,
		COND_START_BAD,
		COND_PATH_FULL,
		COND_AT_END,
		COND_SCAN_MORE,
		COND_NOT_FOUND,
		COND_OUT_BUSY,
		COND_EMIT_MORE
	} cond_t;

	localparam int UPC_W = 4;
	typedef logic [UPC_W-1:0] upc_t;

	// Program addresses.
	localparam upc_t UA_IDLE      = 4'd0;
	localparam upc_t UA_INIT      = 4'd1;
	localparam upc_t UA_CHECK     = 4'd2;
	localparam upc_t UA_RECORD    = 4'd3;
	localparam upc_t UA_SCAN      = 4'd4;
	localparam upc_t UA_DRAIN_A   = 4'd5;
	localparam upc_t UA_DRAIN_B   = 4'd6;
	localparam upc_t UA_DECIDE    = 4'd7;
	localparam upc_t UA_MOVE      = 4'd8;
	localparam upc_t UA_EMIT_INIT = 4'd9;
	localparam upc_t UA_EMIT_READ = 4'd10;
	localparam upc_t UA_EMIT_PUSH = 4'd11;
	localparam upc_t UA_EMIT_NEXT = 4'd12;
	localparam upc_t UA_EMIT_END  = 4'd13;
	localparam upc_t UA_FAIL      = 4'd14;
	localparam upc_t UA_FAIL_END  = 4'd15;

	typedef struct packed {
		act_t  act;
		cond_t cond;
		upc_t  target;
	} uword_t;

	typedef struct packed {
		logic run_taken;
		logic start_bad;
		logic path_full;
		logic at_end;
		logic scan_more;
		logic not_found;
		logic out_busy;
		logic emit_more;
	} seq_status_t;

	// Control store. A taken condition loads target, otherwise the step
	// counter advances by one.
	function automatic uword_t urom(input upc_t addr);
		uword_t w;
		case (addr)
			UA_IDLE:      w = '{ACT_WAIT,      COND_NO_RUN,    UA_IDLE};
			UA_INIT:      w = '{ACT_INIT,      COND_START_BAD, UA_FAIL};
			UA_CHECK:     w = '{ACT_NOP,       COND_PATH_FULL, UA_FAIL};
			UA_RECORD:    w = '{ACT_RECORD,    COND_AT_END,    UA_EMIT_INIT};
			UA_SCAN:      w = '{ACT_SCAN,      COND_SCAN_MORE, UA_SCAN};
			UA_DRAIN_A:   w = '{ACT_NOP,       COND_NEVER,     UA_IDLE};
			UA_DRAIN_B:   w = '{ACT_NOP,       COND_NEVER,     UA_IDLE};
			UA_DECIDE:    w = '{ACT_NOP,       COND_NOT_FOUND, UA_FAIL};
			UA_MOVE:      w = '{ACT_MOVE,      COND_ALWAYS,    UA_CHECK};
			UA_EMIT_INIT: w = '{ACT_EMIT_INIT, COND_NEVER,     UA_IDLE};
			UA_EMIT_READ: w = '{ACT_NOP,       COND_NEVER,     UA_IDLE};
			UA_EMIT_PUSH: w = '{ACT_EMIT_PUSH, COND_OUT_BUSY,  UA_EMIT_PUSH};
			UA_EMIT_NEXT: w = '{ACT_NOP,       COND_EMIT_MORE, UA_EMIT_PUSH};
			UA_EMIT_END:  w = '{ACT_NOP,       COND_ALWAYS,    UA_IDLE};
			UA_FAIL:      w = '{ACT_FAIL_PUSH, COND_OUT_BUSY,  UA_FAIL};
			UA_FAIL_END:  w = '{ACT_NOP,       COND_ALWAYS,    UA_IDLE};
			default:      w = '{ACT_NOP,       COND_ALWAYS,    UA_IDLE};
		endcase
		return w;
	endfunction

endpackage

// File: hw/rtl/priority_guided_path_decoder.sv
// Greedy path decoder over a weighted graph. Load transactions (one per cycle while idle) write an
// edge weight into the adjacency memory or a Q0.16 priority into the priority memory; an
// all-ones weight means no edge. A run transaction walks from start_vertex, at every step
// taking the unvisited neighbor with the smallest priority times edge weight (lowest index
// on a tie), and stops when it reaches end_vertex. A successful run returns one result
// transaction per path vertex with the step weight and a saturating running total, the last
// one flagged; a run that gets stuck, starts out of range or exceeds 32 vertices returns a
// single failure result at the stuck vertex. The time a run takes is set by the single read
// port of the adjacency memory, which the scan sweeps one neighbor per cycle for every path
// step. No new transaction is taken while a run is in progress. Configuration writes are
// taken in every cycle.

`include "priority_guided_path_decoder_defines.svh"

module priority_guided_path_decoder import pgpd_pkg::*; #(
	parameter int NUM_VERTICES  = NUM_VERTICES_DEF,
	parameter int WEIGHT_BITS   = WEIGHT_BITS_DEF,
	parameter int PRIORITY_BITS = PRIORITY_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  in_item_t             in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output out_item_t            out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [VERTEX_W-1:0]  cfg_data
);

	logic [VERTEX_W-1:0] start_vertex_q;
	logic [VERTEX_W-1:0] end_vertex_q;
	uword_t              uword;
	seq_status_t         status;
	logic                in_take;
	logic                run_take;
	logic                fail_shape;

	// Configuration registers accept a write in every cycle.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_vertex_q <= START_RESET;
			end_vertex_q   <= END_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_START_VERTEX: start_vertex_q <= cfg_data;
				CFG_END_VERTEX:   end_vertex_q   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// The sequencer waits in its idle step for input; loads are applied there and a run
	// transaction starts the walk program.
	assign in_ready = (uword.act == ACT_WAIT);
	assign in_take  = in_valid && in_ready;

	pgpd_useq u_useq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.uword  (uword)
	);

	pgpd_dpath #(
		.NUM_VERTICES  (NUM_VERTICES),
		.WEIGHT_BITS   (WEIGHT_BITS),
		.PRIORITY_BITS (PRIORITY_BITS)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.act          (uword.act),
		.in_take      (in_take),
		.in_data      (in_data),
		.start_vertex (start_vertex_q),
		.end_vertex   (end_vertex_q),
		.out_ready    (out_ready),
		.out_valid    (out_valid),
		.out_data     (out_data),
		.status       (status)
	);

	assign run_take   = in_take && (in_data.mode == MODE_RUN);
	assign fail_shape = out_data.last && (out_data.step_weight == '0);

	// A run transaction closes the input until the run has finished.
	`PGPD_ASSERT_NEXT(a_run_closes_input, clk, arst_n, run_take, !in_ready)
	// Results are only produced while a run is in progress.
	`PGPD_ASSERT_SAME(a_result_in_run, clk, arst_n, $rose(out_valid), !in_ready)
	// A failure result is the only result of its run and carries no step weight.
	`PGPD_ASSERT_SAME(a_fail_form, clk, arst_n, out_valid && out_data.failed, fail_shape)

endmodule

// File: hw/rtl/pgpd_ram.sv
module pgpd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: hw/rtl/pgpd_useq.sv
module pgpd_useq import pgpd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  seq_status_t status,
	output uword_t      uword
);

	upc_t upc_q;
	logic take;

	assign uword = urom(upc_q);

	always_comb begin
		case (uword.cond)
			COND_NEVER:     take = 1'b0;
			COND_ALWAYS:    take = 1'b1;
			COND_NO_RUN:    take = !status.run_taken;
			COND_START_BAD: take = status.start_bad;
			COND_PATH_FULL: take = status.path_full;
			COND_AT_END:    take = status.at_end;
			COND_SCAN_MORE: take = status.scan_more;
			COND_NOT_FOUND: take = status.not_found;
			COND_OUT_BUSY:  take = status.out_busy;
			COND_EMIT_MORE: take = status.emit_more;
			default:        take = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= UA_IDLE;
		end else if (take) begin
			upc_q <= uword.target;
		end else begin
			upc_q <= upc_q + upc_t'(1);
		end
	end

endmodule

// File: hw/rtl/pgpd_dpath.sv
module pgpd_dpath import pgpd_pkg::*; #(
	parameter int NUM_VERTICES  = NUM_VERTICES_DEF,
	parameter int WEIGHT_BITS   = WEIGHT_BITS_DEF,
	parameter int PRIORITY_BITS = PRIORITY_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  act_t                act,
	input  logic                in_take,
	input  in_item_t            in_data,
	input  logic [VERTEX_W-1:0] start_vertex,
	input  logic [VERTEX_W-1:0] end_vertex,
	input  logic                out_ready,
	output logic                out_valid,
	output out_item_t           out_data,
	output seq_status_t         status
);

	localparam int VW      = $clog2(NUM_VERTICES);
	localparam int CUR_W   = (VW > VERTEX_W) ? VW : VERTEX_W;
	localparam int CMP_W   = CUR_W + 1;
	localparam int EAW     = 2 * VW;
	localparam int E_DEPTH = 1 << EAW;
	localparam int WB      = WEIGHT_BITS;
	localparam int PB      = PRIORITY_BITS;
	localparam int PROD_W  = WB + PB;
	localparam int SUM_W   = ((WB > TOTAL_W) ? WB : TOTAL_W) + 1;
	localparam int CNT_W   = $clog2(MAX_RESULTS + 1);
	localparam int BUF_AW  = $clog2(MAX_RESULTS);
	localparam int BUF_W   = VW + WB;

	localparam logic [WB-1:0]    NO_EDGE   = {WB{1'b1}};
	localparam logic [CMP_W-1:0] NV_LIM    = CMP_W'(NUM_VERTICES);
	localparam logic [VW-1:0]    SCAN_LAST = VW'(NUM_VERTICES - 1);
	localparam logic [CNT_W-1:0] PATH_MAX  = CNT_W'(MAX_RESULTS);

	function automatic logic [TOTAL_W-1:0] sat_add(input logic [TOTAL_W-1:0] a,
			input logic [WB-1:0] b);
		logic [SUM_W-1:0] s;
		s = SUM_W'(a) + SUM_W'(b);
		if (s > SUM_W'(TOTAL_MAX)) begin
			return TOTAL_MAX;
		end
		return s[TOTAL_W-1:0];
	endfunction

	// Load writes.
	logic [CMP_W-1:0] row_x, col_x;
	logic             edge_we, prio_we;
	logic [EAW-1:0]   edge_waddr, edge_raddr;
	logic [WB-1:0]    edge_rd;
	logic [PB-1:0]    prio_rd;

	assign row_x      = CMP_W'(in_data.row_vertex);
	assign col_x      = CMP_W'(in_data.col_vertex);
	assign edge_we    = in_take && (in_data.mode == MODE_EDGE) && (row_x < NV_LIM)
		&& (col_x < NV_LIM);
	assign prio_we    = in_take && (in_data.mode == MODE_PRIO) && (row_x < NV_LIM);
	assign edge_waddr = {row_x[VW-1:0], col_x[VW-1:0]};

	// Walk state.
	logic [CUR_W-1:0]        cur_q;
	logic [TOTAL_W-1:0]      total_q;
	logic [WB-1:0]           step_q;
	logic [CNT_W-1:0]        n_q, k_q, k_nxt;
	logic [NUM_VERTICES-1:0] visited_q;
	logic [VW-1:0]           scan_q;

	// Scan pipeline.
	logic              iss_s1, vis_s1;
	logic [VW-1:0]     idx_s1, idx_s2;
	logic              ok_s2;
	logic [PROD_W-1:0] prod_s2;
	logic [WB-1:0]     w_s2;

	logic              best_found_q;
	logic [PROD_W-1:0] best_cost_q;
	logic [VW-1:0]     best_idx_q;
	logic [WB-1:0]     best_w_q;

	// Path buffer.
	logic             buf_we;
	logic [BUF_W-1:0] buf_rd;
	logic [WB-1:0]    buf_step;
	logic [TOTAL_W-1:0] emit_total;

	// Output register.
	logic      out_valid_q;
	out_item_t out_data_q;
	logic      out_busy, push;

	assign edge_raddr = {cur_q[VW-1:0], scan_q};
	assign buf_we     = (act == ACT_RECORD);
	assign buf_step   = buf_rd[WB-1:0];
	assign emit_total = sat_add(total_q, buf_step);
	assign k_nxt      = k_q + CNT_W'(1);

	pgpd_ram #(.WIDTH(WB), .DEPTH(E_DEPTH)) u_edge_ram (
		.clk   (clk),
		.we    (edge_we),
		.waddr (edge_waddr),
		.wdata (WB'(in_data.edge_weight)),
		.raddr (edge_raddr),
		.rdata (edge_rd)
	);

	pgpd_ram #(.WIDTH(PB), .DEPTH(NUM_VERTICES)) u_prio_ram (
		.clk   (clk),
		.we    (prio_we),
		.waddr (row_x[VW-1:0]),
		.wdata (PB'(in_data.priority_value)),
		.raddr (scan_q),
		.rdata (prio_rd)
	);

	pgpd_ram #(.WIDTH(BUF_W), .DEPTH(MAX_RESULTS)) u_path_ram (
		.clk   (clk),
		.we    (buf_we),
		.waddr (n_q[BUF_AW-1:0]),
		.wdata ({cur_q[VW-1:0], step_q}),
		.raddr (k_q[BUF_AW-1:0]),
		.rdata (buf_rd)
	);

	assign out_busy = out_valid_q && !out_ready;
	assign push     = ((act == ACT_EMIT_PUSH) || (act == ACT_FAIL_PUSH)) && !out_busy;

	always_comb begin
		status.run_taken = in_take && (in_data.mode == MODE_RUN);
		status.start_bad = CMP_W'(start_vertex) >= NV_LIM;
		status.path_full = (n_q == PATH_MAX);
		status.at_end    = (cur_q == CUR_W'(end_vertex));
		status.scan_more = (scan_q != SCAN_LAST);
		status.not_found = !best_found_q;
		status.out_busy  = out_busy;
		status.emit_more = (k_q != n_q);
	end

	// Walk registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q     <= '0;
			total_q   <= '0;
			n_q       <= '0;
			k_q       <= '0;
			visited_q <= '0;
			scan_q    <= '0;
		end else begin
			case (act)
				ACT_INIT: begin
					visited_q <= '0;
					total_q   <= '0;
					cur_q     <= CUR_W'(start_vertex);
					n_q       <= '0;
				end
				ACT_RECORD: begin
					n_q                      <= n_q + CNT_W'(1);
					visited_q[cur_q[VW-1:0]] <= 1'b1;
					scan_q                   <= '0;
				end
				ACT_SCAN: begin
					scan_q <= scan_q + VW'(1);
				end
				ACT_MOVE: begin
					cur_q   <= CUR_W'(best_idx_q);
					total_q <= sat_add(total_q, best_w_q);
				end
				ACT_EMIT_INIT: begin
					k_q     <= '0;
					total_q <= '0;
				end
				ACT_EMIT_PUSH: begin
					if (!out_busy) begin
						k_q     <= k_nxt;
						total_q <= emit_total;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// The first path vertex is reached by no edge.
	always_ff @(posedge clk) begin
		if (act == ACT_INIT) begin
			step_q <= '0;
		end else if (act == ACT_MOVE) begin
			step_q <= best_w_q;
		end
	end

	// Scan pipeline: address issue, memory read, product, compare.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iss_s1       <= 1'b0;
			ok_s2        <= 1'b0;
			best_found_q <= 1'b0;
		end else begin
			iss_s1 <= (act == ACT_SCAN);
			ok_s2  <= iss_s1 && !vis_s1 && (edge_rd != NO_EDGE);
			if (act == ACT_RECORD) begin
				best_found_q <= 1'b0;
			end else if (ok_s2 && (!best_found_q || (prod_s2 < best_cost_q))) begin
				best_found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1  <= scan_q;
		vis_s1  <= visited_q[scan_q];
		idx_s2  <= idx_s1;
		w_s2    <= edge_rd;
		prod_s2 <= PROD_W'(prio_rd) * PROD_W'(edge_rd);
		// Strict compare in ascending order keeps the lowest index on a tie.
		if (ok_s2 && (!best_found_q || (prod_s2 < best_cost_q))) begin
			best_cost_q <= prod_s2;
			best_idx_q  <= idx_s2;
			best_w_q    <= w_s2;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			if (act == ACT_FAIL_PUSH) begin
				out_data_q.vertex       <= VERTEX_W'(cur_q);
				out_data_q.step_weight  <= '0;
				out_data_q.total_weight <= total_q;
				out_data_q.last         <= 1'b1;
				out_data_q.failed       <= 1'b1;
			end else begin
				out_data_q.vertex       <= VERTEX_W'(buf_rd[BUF_W-1 -: VW]);
				out_data_q.step_weight  <= WEIGHT_FIELD_W'(buf_step);
				out_data_q.total_weight <= emit_total;
				out_data_q.last         <= (k_nxt == n_q);
				out_data_q.failed       <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule
